// ===== sv/spx_pkg.sv =====
// Package for the sprite entry tile expander: field positions, position constants,
// and the row descriptor passed between the front end, the queue and the back end.
// No dependencies.
package spx_pkg;

    // attribute byte fields
    localparam int AttrEnable = 0;
    localparam int AttrYMsb   = 1;
    localparam int AttrXMsb   = 2;
    localparam int AttrYFlip  = 3;
    localparam int AttrXFlip  = 4;
    localparam int AttrHeightLo = 5;
    localparam int AttrHeightHi = 7;

    // position constants
    localparam logic [8:0] XWrapLimit = 9'h17f;
    localparam logic [9:0] YBaseHigh  = 10'd495;   // 239 + 256
    localparam logic [9:0] YBaseLow   = 10'd240;
    localparam logic [9:0] FlipXBase  = 10'd304;
    localparam logic [9:0] FlipYBase  = 10'd224;
    localparam logic [9:0] RowStep    = 10'd16;

    localparam int QueueDepthDefault = 2;

    typedef struct packed {
        logic [15:0] base;
        logic [3:0]  colour;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [2:0]  height;
        logic        step_down;   // rows step by +16 (screen flipped)
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

endpackage

// ===== sv/spx_if.sv =====
// Handshake interfaces for sprite entries in and tile commands out.
// No dependencies.
interface spx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] y_byte;
    logic [7:0] attr_byte;
    logic [7:0] tile_byte;
    logic [7:0] bank_byte;
    logic [3:0] colour_in;
    logic [7:0] x_byte;

    modport source (output valid, y_byte, attr_byte, tile_byte, bank_byte, colour_in,
                    x_byte, input ready);
    modport sink   (input valid, y_byte, attr_byte, tile_byte, bank_byte, colour_in,
                    x_byte, output ready);
endinterface

interface spx_out_if;
    logic              valid;
    logic              ready;
    logic [15:0]       tile_code;
    logic [3:0]        colour_out;
    logic              flip_x;
    logic              flip_y;
    logic signed [9:0] screen_x;
    logic signed [9:0] screen_y;
    logic              last_row;

    modport source (output valid, tile_code, colour_out, flip_x, flip_y, screen_x,
                    screen_y, last_row, input ready);
    modport sink   (input valid, tile_code, colour_out, flip_x, flip_y, screen_x,
                    screen_y, last_row, output ready);
    modport mon    (input valid, ready, tile_code, colour_out, flip_x, flip_y, screen_x,
                    screen_y, last_row);
endinterface

// ===== sv/spx_front.sv =====
// Front end: accepts sprite entries, drops disabled ones, computes base code and
// screen position. Holds the screen flip register. Depends on spx_pkg, spx_if.
module spx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    spx_in_if.sink           i_item,
    input  logic             i_q_full,
    output spx_pkg::t_push   o_push
);
    import spx_pkg::*;

    logic       r_screen_flip;
    logic [8:0] x9;
    logic [9:0] sx_raw;
    logic [9:0] sy_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_flip <= 1'b0;
        end else if (i_cfg_we) begin
            r_screen_flip <= i_cfg_wdata;
        end
    end

    assign i_item.ready = !i_q_full;

    always_comb begin
        x9     = {i_item.attr_byte[AttrXMsb], i_item.x_byte};
        // 0x180..0x1ff wrap negative
        sx_raw = (x9 > XWrapLimit) ? {1'b1, x9} : {1'b0, x9};
        sy_raw = i_item.attr_byte[AttrYMsb] ? (YBaseHigh - {2'b00, i_item.y_byte})
                                            : (YBaseLow  - {2'b00, i_item.y_byte});

        o_push.valid          = i_item.valid && !i_q_full && i_item.attr_byte[AttrEnable];
        o_push.desc.base      = {i_item.bank_byte, i_item.tile_byte};
        o_push.desc.colour    = i_item.colour_in;
        o_push.desc.flip_x    = i_item.attr_byte[AttrXFlip] ^ r_screen_flip;
        o_push.desc.flip_y    = i_item.attr_byte[AttrYFlip] ^ r_screen_flip;
        o_push.desc.sx        = r_screen_flip ? (FlipXBase - sx_raw) : sx_raw;
        o_push.desc.sy        = r_screen_flip ? (FlipYBase - sy_raw) : sy_raw;
        o_push.desc.height    = i_item.attr_byte[AttrHeightHi:AttrHeightLo];
        o_push.desc.step_down = r_screen_flip;
    end

endmodule

// ===== sv/spx_queue.sv =====
// Short register queue of entry descriptors between front and back end.
// Depends on spx_pkg.
module spx_queue #(
    parameter int Depth = spx_pkg::QueueDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spx_pkg::t_push  i_push,
    output logic            o_full,
    output logic            o_valid,
    output spx_pkg::t_desc  o_desc,
    input  logic            i_pop
);
    import spx_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_desc           r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/spx_back.sv =====
// Back end: expands one descriptor into height+1 tile commands, one per cycle while the
// output is not stalled, into a registered output stage. Depends on spx_pkg, spx_if.
module spx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  spx_pkg::t_desc  i_q_desc,
    output logic            o_pop,
    spx_out_if.source       o_cmd
);
    import spx_pkg::*;

    logic        r_busy;
    t_desc       r_desc;
    logic [2:0]  r_row;
    logic [9:0]  r_y;
    logic [15:0] r_code;

    logic        r_ovalid;
    logic [15:0] r_o_code;
    logic [3:0]  r_o_colour;
    logic        r_o_fx;
    logic        r_o_fy;
    logic [9:0]  r_o_x;
    logic [9:0]  r_o_y;
    logic        r_o_last;

    logic        can_emit;
    logic        is_last;

    assign can_emit = r_busy && (!r_ovalid || o_cmd.ready);
    assign is_last  = (r_row == r_desc.height);
    assign o_pop    = i_q_valid && (!r_busy || (can_emit && is_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (can_emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (can_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // row walk
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
            r_row  <= '0;
            r_y    <= i_q_desc.sy;
            r_code <= i_q_desc.base;
        end else if (can_emit) begin
            r_row  <= r_row + 1'b1;
            r_y    <= r_desc.step_down ? (r_y + RowStep) : (r_y - RowStep);
            r_code <= r_code + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_emit) begin
            r_o_code   <= r_code;
            r_o_colour <= r_desc.colour;
            r_o_fx     <= r_desc.flip_x;
            r_o_fy     <= r_desc.flip_y;
            r_o_x      <= r_desc.sx;
            r_o_y      <= r_y;
            r_o_last   <= is_last;
        end
    end

    assign o_cmd.valid      = r_ovalid;
    assign o_cmd.tile_code  = r_o_code;
    assign o_cmd.colour_out = r_o_colour;
    assign o_cmd.flip_x     = r_o_fx;
    assign o_cmd.flip_y     = r_o_fy;
    assign o_cmd.screen_x   = $signed(r_o_x);
    assign o_cmd.screen_y   = $signed(r_o_y);
    assign o_cmd.last_row   = r_o_last;

endmodule

// ===== sv/sprite_entry_tile_expander.sv =====
// Sprite entry tile expander top level: entries pass the queue, the back-end row
// registers and the output stage. Throughput: one command per cycle unless o_cmd stalls;
// an entry gives height+1 commands (1 to 8); disabled entries never reach the back end.
// Reset (i_rst_n, synchronous, active low) empties the queue, clears the output stage and
// sets screen flip to 0. Depends on spx_pkg, spx_if and submodules.
module sprite_entry_tile_expander #(
    parameter int QueueDepth = spx_pkg::QueueDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    spx_in_if.sink     i_item,
    spx_out_if.source  o_cmd
);
    import spx_pkg::*;

    // front -> queue: push word with precomputed position and flips
    t_push push;
    logic  q_full;
    // queue -> back
    logic  q_valid;
    t_desc q_desc;
    logic  q_pop;

    // front end: classify entry, compute base code and screen position
    spx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_push      (push)
    );

    // decouples entry intake from row expansion
    spx_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (q_pop)
    );

    // back end: one command per row, registered output
    spx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_desc),
        .o_pop     (q_pop),
        .o_cmd     (o_cmd)
    );

endmodule

// ===== sv/spx_chk.sv =====
// Port-level checker for the sprite entry tile expander, bound to the top level.
// Depends on the top level's clock, reset and o_cmd port only.
module spx_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready,
    input  logic [15:0]       i_tile_code,
    input  logic [3:0]        i_colour_out,
    input  logic              i_flip_x,
    input  logic              i_flip_y,
    input  logic signed [9:0] i_screen_x,
    input  logic signed [9:0] i_screen_y,
    input  logic              i_last_row
);

    // output empty right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_valid)
        else $error("command valid after reset");

    // stalled word stays valid with its code, y and last flag held
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && !i_ready) |-> i_valid && $stable(i_tile_code)
            && $stable(i_screen_y) && $stable(i_last_row))
        else $error("stalled command changed");

    // rows of one entry: code counts up, x and attributes stay
    a_row_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && i_ready && !i_last_row) && i_valid |->
            i_tile_code == $past(i_tile_code) + 16'd1
            && i_screen_x == $past(i_screen_x)
            && i_colour_out == $past(i_colour_out)
            && i_flip_x == $past(i_flip_x) && i_flip_y == $past(i_flip_y))
        else $error("row sequence broken");

    // rows of one entry step y by 16
    a_row_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_valid && i_ready && !i_last_row) && i_valid |->
            (i_screen_y - $past(i_screen_y)) == 10'sd16
            || ($past(i_screen_y) - i_screen_y) == 10'sd16)
        else $error("row y step wrong");

endmodule

bind sprite_entry_tile_expander spx_chk u_spx_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_cmd.valid),
    .i_ready      (o_cmd.ready),
    .i_tile_code  (o_cmd.tile_code),
    .i_colour_out (o_cmd.colour_out),
    .i_flip_x     (o_cmd.flip_x),
    .i_flip_y     (o_cmd.flip_y),
    .i_screen_x   (o_cmd.screen_x),
    .i_screen_y   (o_cmd.screen_y),
    .i_last_row   (o_cmd.last_row)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for sprite_entry_tile_expander: drives sprite entries
// with random gaps in most phases, predicts every tile command and checks it field by field.
// Depends on spx_pkg, spx_if and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spx_pkg::*;

    // one sprite-list entry as offered on the input channel
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] attr;
        logic [7:0] tile;
        logic [7:0] bank;
        logic [3:0] colour;
        logic [7:0] x;
    } t_entry;

    // one tile command as seen on the output channel
    typedef struct packed {
        logic [15:0]       code;
        logic [3:0]        colour;
        logic              fx;
        logic              fy;
        logic signed [9:0] sx;
        logic signed [9:0] sy;
        logic              last;
    } t_cmd;

    // Holds the tile commands still owed by the block, in order, plus its own
    // copy of the screen flip register.
    class tile_cmd_board;
        logic screen_flip;
        t_cmd pending_cmds[$];
        int   failures;

        function new();
            screen_flip = 1'b0;
            failures    = 0;
        endfunction

        // expand one accepted entry into its row commands
        function void add_entry(t_entry e);
            int         px;
            int         py;
            int         row_y;
            logic       fx;
            logic       fy;
            logic [2:0] rows_m1;
            logic [15:0] base;
            t_cmd       c;
            // disabled entry: nothing drawn, other attribute bits don't matter
            if (!e.attr[AttrEnable])
                return;
            fx      = e.attr[AttrXFlip];
            fy      = e.attr[AttrYFlip];
            rows_m1 = e.attr[AttrHeightHi:AttrHeightLo];
            base    = {e.bank, e.tile};
            // nine-bit x, upper part of the range folds to negative
            px = int'({e.attr[AttrXMsb], e.x});
            if (px > int'(XWrapLimit))
                px = px - 'h200;
            if (e.attr[AttrYMsb])
                py = int'(YBaseHigh) - int'(e.y);
            else
                py = int'(YBaseLow) - int'(e.y);
            if (screen_flip) begin
                px = int'(FlipXBase) - px;
                py = int'(FlipYBase) - py;
                fx = !fx;
                fy = !fy;
            end
            for (int r = 0; r <= int'(rows_m1); r++) begin
                row_y    = screen_flip ? py + r * int'(RowStep) : py - r * int'(RowStep);
                c.code   = base + 16'(r);     // wraps past 0xffff
                c.colour = e.colour;
                c.fx     = fx;
                c.fy     = fy;
                c.sx     = px[9:0];
                c.sy     = row_y[9:0];
                c.last   = (r == int'(rows_m1));
                pending_cmds.push_back(c);
            end
        endfunction

        function void report(string field, logic signed [16:0] want,
                             logic signed [16:0] got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        endfunction

        function void check_cmd(t_cmd got);
            t_cmd want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected tile command, actual code %0d x %0d y %0d",
                         $time, got.code, got.sx, got.sy);
                failures++;
                return;
            end
            want = pending_cmds.pop_front();
            if (got.code !== want.code)     report("tile_code", want.code, got.code);
            if (got.colour !== want.colour) report("colour_out", want.colour, got.colour);
            if (got.fx !== want.fx)         report("flip_x", want.fx, got.fx);
            if (got.fy !== want.fy)         report("flip_y", want.fy, got.fy);
            if (got.sx !== want.sx)         report("screen_x", want.sx, got.sx);
            if (got.sy !== want.sy)         report("screen_y", want.sy, got.sy);
            if (got.last !== want.last)     report("last_row", want.last, got.last);
        endfunction

        function bit empty();
            return pending_cmds.size() == 0;
        endfunction
    endclass

    localparam int StallLimit = 1000;   // cycles with no word moving on either side
    localparam int HoldCycles = 90;     // length of a long receiver hold-off

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    spx_in_if  in_bus();
    spx_out_if cmd_bus();

    sprite_entry_tile_expander u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_bus),
        .o_cmd       (cmd_bus)
    );

    tile_cmd_board board = new();

    bit gaps_on;          // random idling on both sides
    int cmd_total;        // tile commands accepted so far
    int stall_cycles;     // consecutive cycles with nothing accepted
    int hold_left;
    int holds_done;
    int hold_marks[2] = '{120, 700};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor: everything is sampled at the rising edge, inputs move on the
    // falling edge, so the values seen here are settled.
    always @(posedge i_clk) begin
        t_entry e;
        t_cmd   c;
        if (i_rst_n) begin
            if (i_cfg_we)
                board.screen_flip = i_cfg_wdata;
            if (in_bus.valid && in_bus.ready) begin
                e.y      = in_bus.y_byte;
                e.attr   = in_bus.attr_byte;
                e.tile   = in_bus.tile_byte;
                e.bank   = in_bus.bank_byte;
                e.colour = in_bus.colour_in;
                e.x      = in_bus.x_byte;
                board.add_entry(e);
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                c.code   = cmd_bus.tile_code;
                c.colour = cmd_bus.colour_out;
                c.fx     = cmd_bus.flip_x;
                c.fy     = cmd_bus.flip_y;
                c.sx     = cmd_bus.screen_x;
                c.sy     = cmd_bus.screen_y;
                c.last   = cmd_bus.last_row;
                board.check_cmd(c);
                cmd_total++;
            end
            if ((in_bus.valid && in_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Receiver: random stalls, plus two long hold-offs once enough commands
    // have gone by, so the internal queue fills and input ready drops.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            cmd_bus.ready <= 1'b0;
            hold_left--;
        end else if (holds_done < 2 && cmd_total >= hold_marks[holds_done]) begin
            cmd_bus.ready <= 1'b0;
            hold_left = HoldCycles - 1;
            holds_done++;
        end else begin
            cmd_bus.ready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;
        end
    end

    // Offer one entry, wait for it to be taken; returns on a falling edge with
    // valid still high so back-to-back words need no bubble.
    task automatic send_entry(input t_entry e);
        while (gaps_on && $urandom_range(99) < 35) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.y_byte    <= e.y;
        in_bus.attr_byte <= e.attr;
        in_bus.tile_byte <= e.tile;
        in_bus.bank_byte <= e.bank;
        in_bus.colour_in <= e.colour;
        in_bus.x_byte    <= e.x;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    // Register write with the block idle. Disabled entries owe nothing, so the
    // task idles on after the board empties before writing.
    task automatic write_flip(input logic flip);
        in_bus.valid <= 1'b0;
        while (!board.empty())
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_wdata <= flip;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Corners: origin, x wrap edges, y msb, tile code wrap, flips, heights,
    // disabled entries with other bits set.
    //            y      attr   tile   bank   col   x
    task automatic run_directed();
        send_entry({8'h00, 8'h01, 8'h00, 8'h00, 4'h0, 8'h00});
        send_entry({8'hff, 8'h03, 8'hff, 8'h00, 4'hf, 8'hff});
        send_entry({8'h10, 8'h05, 8'h12, 8'h34, 4'h5, 8'h7f});  // x = 0x17f, stays positive
        send_entry({8'h10, 8'h05, 8'h12, 8'h34, 4'ha, 8'h80});  // x = 0x180, wraps negative
        send_entry({8'h00, 8'h1f, 8'h01, 8'h80, 4'h3, 8'hff});  // both flips, x = -1
        send_entry({8'h20, 8'he1, 8'hff, 8'hff, 4'h9, 8'h40});  // tile code wraps past 0xffff
        send_entry({8'hff, 8'hfe, 8'hff, 8'hff, 4'hf, 8'hff});  // disabled, rest all ones
        send_entry({8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00});  // disabled, all zero
        send_entry({8'h55, 8'h69, 8'haa, 8'h55, 4'h6, 8'h33});  // yflip, four rows
        send_entry({8'haa, 8'h31, 8'h55, 8'haa, 4'hc, 8'hcc});  // xflip, two rows
        send_entry({8'hff, 8'hff, 8'hff, 8'hff, 4'hf, 8'hff});  // every bit set
        send_entry({8'h80, 8'ha3, 8'h07, 8'h01, 4'h1, 8'h40});  // y msb, six rows
    endtask

    // Random entries, mostly enabled.
    task automatic run_random(input int n_items);
        t_entry e;
        int     sent;
        sent = 0;
        while (sent < n_items) begin
            e.y      = 8'($urandom_range(255));
            e.attr   = 8'($urandom_range(255));
            e.tile   = 8'($urandom_range(255));
            e.bank   = 8'($urandom_range(255));
            e.colour = 4'($urandom_range(15));
            e.x      = 8'($urandom_range(255));
            e.attr[AttrEnable] = ($urandom_range(99) < 85);
            sent++;
            send_entry(e);
        end
    endtask

    // End of run on a stuck handshake.
    initial begin
        while (stall_cycles < StallLimit)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.y_byte       = 8'h00;
        in_bus.attr_byte    = 8'h00;
        in_bus.tile_byte    = 8'h00;
        in_bus.bank_byte    = 8'h00;
        in_bus.colour_in    = 4'h0;
        in_bus.x_byte       = 8'h00;
        gaps_on             = 1'b1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners, unflipped then flipped
        write_flip(1'b0);
        run_directed();
        write_flip(1'b1);
        run_directed();

        // random phases across both flip settings
        write_flip(1'b0);
        run_random(60);
        write_flip(1'b1);
        run_random(55);
        write_flip(1'b0);
        gaps_on <= 1'b0;      // long stretch at full rate on both sides
        run_random(45);
        write_flip(1'b1);
        gaps_on <= 1'b1;
        run_random(45);

        in_bus.valid <= 1'b0;
        while (!board.empty())
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sprite_entry_tile_expander.f =====
sv/spx_pkg.sv
sv/spx_if.sv
sv/spx_front.sv
sv/spx_queue.sv
sv/spx_back.sv
sv/sprite_entry_tile_expander.sv
sv/spx_chk.sv
sim/testbench.sv
